// File: rtl/csa_pkg.sv
package csa_pkg;

  localparam int Width = 32;
  localparam int DivSteps = Width;
  localparam int CntW = $clog2(DivSteps + 1);
  localparam int QueueDepth = 4;
  localparam int QPtrW = $clog2(QueueDepth);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_ABS = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [Width-1:0] MinVal = {1'b1, {(Width-1){1'b0}}};
  localparam logic [Width-1:0] MaxVal = {1'b0, {(Width-1){1'b1}}};
  localparam logic [Width-1:0] NegOne = {Width{1'b1}};

  typedef enum logic [1:0] {
    KIND_IMM = 2'd0,
    KIND_MUL = 2'd1,
    KIND_DIV = 2'd2
  } kind_t;

  // classified work item handed from front to back
  typedef struct packed {
    kind_t            kind;
    logic             neg;
    logic [1:0]       st;
    logic [Width-1:0] res;
    logic [Width-1:0] ma;
    logic [Width-1:0] mb;
  } item_t;

endpackage

// File: rtl/csa_if.sv
interface csa_req_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        req_type;
  logic signed [csa_pkg::Width-1:0]  operand_a;
  logic signed [csa_pkg::Width-1:0]  operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface csa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [csa_pkg::Width-1:0]  result;
  logic [1:0]                        status;

  modport source (output valid, result, status, input ready);
  modport sink (input valid, result, status, output ready);
endinterface

// File: rtl/csa_front.sv
module csa_front (
  input  logic [2:0]               req_type,
  input  logic [csa_pkg::Width-1:0] a,
  input  logic [csa_pkg::Width-1:0] b,
  output csa_pkg::item_t           item
);

  logic [csa_pkg::Width-1:0] sum;
  logic [csa_pkg::Width-1:0] diff;
  logic [csa_pkg::Width-1:0] ma;
  logic [csa_pkg::Width-1:0] mb;
  logic                      sa;
  logic                      sb;

  assign sa   = a[csa_pkg::Width-1];
  assign sb   = b[csa_pkg::Width-1];
  assign sum  = a + b;
  assign diff = a - b;
  assign ma   = sa ? (~a + 1'b1) : a;
  assign mb   = sb ? (~b + 1'b1) : b;

  always_comb begin
    item.kind = csa_pkg::KIND_IMM;
    item.neg  = sa ^ sb;
    item.st   = csa_pkg::ST_OK;
    item.res  = '0;
    item.ma   = ma;
    item.mb   = mb;
    unique case (req_type)
      csa_pkg::OP_ADD: begin
        if (sa == sb && sum[csa_pkg::Width-1] != sa) item.st = csa_pkg::ST_OVF;
        else item.res = sum;
      end
      csa_pkg::OP_SUB: begin
        if (sa != sb && diff[csa_pkg::Width-1] != sa) item.st = csa_pkg::ST_OVF;
        else item.res = diff;
      end
      csa_pkg::OP_MUL: item.kind = csa_pkg::KIND_MUL;
      csa_pkg::OP_DIV: begin
        if (b == '0) item.st = csa_pkg::ST_DIV0;
        else if (a == csa_pkg::MinVal && b == csa_pkg::NegOne) item.st = csa_pkg::ST_OVF;
        else item.kind = csa_pkg::KIND_DIV;
      end
      csa_pkg::OP_ABS: begin
        if (a == csa_pkg::MinVal) item.st = csa_pkg::ST_OVF;
        else item.res = ma;
      end
      default: item.st = csa_pkg::ST_OVF;
    endcase
  end

endmodule

// File: rtl/csa_queue.sv
module csa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  csa_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output csa_pkg::item_t head_item
);

  csa_pkg::item_t              mem_r [csa_pkg::QueueDepth];
  logic [csa_pkg::QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [csa_pkg::QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [csa_pkg::QPtrW:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == (csa_pkg::QPtrW+1)'(csa_pkg::QueueDepth));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (csa_pkg::QPtrW+1)'(push) - (csa_pkg::QPtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// File: rtl/csa_back.sv
module csa_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  csa_pkg::item_t            head_item,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [csa_pkg::Width-1:0] out_result,
  output logic [1:0]                out_status
);

  localparam int W = csa_pkg::Width;

  logic                  s1_v_r, s1_v_nxt;
  csa_pkg::kind_t        kind_r;
  logic                  neg_r;
  logic [1:0]            st_r;
  logic [W-1:0]          res_r;
  logic [W-1:0]          mb_r;
  logic [2*W-1:0]        prod_r;
  logic [W-1:0]          quo_r;
  logic [W-1:0]          rem_r;
  logic [csa_pkg::CntW-1:0] cnt_r;

  logic                  ov_r, ov_nxt;
  logic [W-1:0]          ores_r;
  logic [1:0]            ost_r;

  logic                  done;
  logic                  adv;
  logic [W:0]            rem_sh;
  logic [W:0]            trial;
  logic [2*W-1:0]        limit;
  logic [W-1:0]          fin_res;
  logic [1:0]            fin_st;

  assign done = (kind_r != csa_pkg::KIND_DIV) || (cnt_r == '0);
  assign adv  = s1_v_r && done && (!ov_r || out_ready);
  assign pop  = head_valid && (!s1_v_r || adv);

  // one restoring divide step per cycle
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign trial  = rem_sh - {1'b0, mb_r};
  assign limit  = neg_r ? (2*W)'(csa_pkg::MinVal) : (2*W)'(csa_pkg::MaxVal);

  always_comb begin
    fin_res = res_r;
    fin_st  = st_r;
    case (kind_r)
      csa_pkg::KIND_MUL: begin
        if (prod_r > limit) begin
          fin_st  = csa_pkg::ST_OVF;
          fin_res = '0;
        end else begin
          fin_st  = csa_pkg::ST_OK;
          fin_res = neg_r ? (~prod_r[W-1:0] + 1'b1) : prod_r[W-1:0];
        end
      end
      csa_pkg::KIND_DIV: begin
        fin_st  = csa_pkg::ST_OK;
        fin_res = neg_r ? (~quo_r + 1'b1) : quo_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    s1_v_nxt = pop ? 1'b1 : (adv ? 1'b0 : s1_v_r);
    ov_nxt   = adv ? 1'b1 : ((ov_r && out_ready) ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      ov_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      ov_r   <= ov_nxt;
      if (pop) begin
        cnt_r <= (head_item.kind == csa_pkg::KIND_DIV) ?
                 csa_pkg::CntW'(csa_pkg::DivSteps) : '0;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= head_item.kind;
      neg_r  <= head_item.neg;
      st_r   <= head_item.st;
      res_r  <= head_item.res;
      mb_r   <= head_item.mb;
      prod_r <= head_item.ma * head_item.mb;
      quo_r  <= head_item.ma;
      rem_r  <= '0;
    end else if (cnt_r != '0) begin
      if (!trial[W]) begin
        rem_r <= trial[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
    if (adv) begin
      ores_r <= fin_res;
      ost_r  <= fin_st;
    end
  end

  assign out_valid  = ov_r;
  assign out_result = ores_r;
  assign out_status = ost_r;

endmodule

// File: rtl/checked_signed_alu.sv
// Overflow-checked signed ALU.
// in_req carries req_type (add, sub, mul, div, abs of A) and two signed
// operands; out_rsp returns result and status (ok, overflow, divide by zero).
// A transfer happens on a clock edge with valid and ready both high.
// The front classifies each request and settles add, sub, abs and all error
// cases but multiply overflow at once; a four-entry queue feeds the back end,
// which runs multiply (with its overflow check) through one 32x32 multiplier
// and divide through a radix-2 restoring divider, one step per quotient bit.
// A result passes from the queue through the back-end stage register to the
// output register. Throughput: one request per cycle while the queue has
// room; each divide holds the back end, and later requests collect in the queue.
// Results leave in request order from an output register. While out_rsp.ready
// is low the result holds, the back end stops and in_req.ready drops once the
// queue fills. Synchronous reset empties the queue and drops all valids.
module checked_signed_alu (
  input  logic      clk,
  input  logic      rst_n,
  csa_req_if.sink   in_req,
  csa_rsp_if.source out_rsp
);

  csa_pkg::item_t item;
  csa_pkg::item_t head_item;
  logic           full;
  logic           pop;
  logic           head_valid;
  logic           push;
  logic [csa_pkg::Width-1:0] res;

  assign in_req.ready = !full;
  assign push         = in_req.valid && !full;

  csa_front u_front (
    .req_type (in_req.req_type),
    .a        (in_req.operand_a),
    .b        (in_req.operand_b),
    .item     (item)
  );

  csa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  csa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_rsp.valid),
    .out_ready  (out_rsp.ready),
    .out_result (res),
    .out_status (out_rsp.status)
  );

  assign out_rsp.result = res;

endmodule
